// ----- rtl/binary_to_radix_digits_macros.svh -----
// assertion helpers shared by the rtl
`ifndef BINARY_TO_RADIX_DIGITS_MACROS_SVH
`define BINARY_TO_RADIX_DIGITS_MACROS_SVH

// same-cycle implication
`define B2RD_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define B2RD_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/b2rd_pkg.sv -----
package b2rd_pkg;

  localparam int VALUE_W         = 31;
  localparam int DIGIT_W         = 4;
  localparam int RADIX_W         = 4;
  localparam int WORK_W          = 32;
  localparam int STEPS_PER_CYCLE = 8;
  localparam int DIV_CYCLES      = WORK_W / STEPS_PER_CYCLE;
  localparam int DIV_CNT_W       = $clog2(DIV_CYCLES);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd10;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT_RD,
    ST_EMIT_LD
  } b2rd_state_t;

  typedef struct packed {
    logic load;
    logic div;
    logic emit_rd;
    logic emit_ld;
  } b2rd_cmd_t;

  typedef struct packed {
    logic div_last;
    logic conv_done;
    logic ptr_zero;
    logic out_free;
  } b2rd_status_t;

endpackage

// ----- rtl/binary_to_radix_digits.sv -----
// Converts a 31-bit non-negative integer into its digits in base 2 to 10 (written through
// the configuration channel, saturated into that range, reset value 10) and sends them
// most significant first, one digit per output beat, with last set on the least
// significant digit; zero gives a single 0 digit. One item is converted at a time: the
// input is stalled from acceptance until the final digit has been loaded into the output
// register. The shared divider produces 8 quotient bits per cycle while dividing; when all
// digits are in the digit buffer, each is read back from it (read state) and then loaded
// into the output register (load state), which waits while the output holds a stalled
// digit. At most MAX_DIGITS least significant digits are kept and sent.
`include "binary_to_radix_digits_macros.svh"

module binary_to_radix_digits
  import b2rd_pkg::*;
#(
  parameter int MAX_DIGITS = 31
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RADIX_W-1:0] radix,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DIGIT_W-1:0] digit,
  output logic               last
);

  b2rd_cmd_t    cmd;
  b2rd_status_t status;

  assign cfg_ready = 1'b1;

  b2rd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  b2rd_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .radix     (radix),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .digit     (digit),
    .last      (last),
    .cmd       (cmd),
    .status    (status)
  );

  `B2RD_ASSERT_IMP(a_digit_range, clk, rst, out_valid, digit <= 4'd9, "digit out of range")
  `B2RD_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "not busy")
  `B2RD_ASSERT_IMP(a_busy_mid_run, clk, rst, out_valid && !last, in_stall, "accepting mid run")

endmodule

// ----- rtl/b2rd_ram.sv -----
module b2rd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/b2rd_ctrl.sv -----
module b2rd_ctrl
  import b2rd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  b2rd_status_t status,
  output b2rd_cmd_t    cmd
);

  b2rd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (status.div_last && status.conv_done) begin
          state_next = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (status.out_free) begin
          cmd.emit_ld = 1'b1;
          state_next  = status.ptr_zero ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/b2rd_dp.sv -----
module b2rd_dp
  import b2rd_pkg::*;
#(
  parameter int MAX_DIGITS = 31,
  localparam int ADDR_W = $clog2(MAX_DIGITS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [RADIX_W-1:0] radix,
  input  logic [VALUE_W-1:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DIGIT_W-1:0] digit,
  output logic               last,
  input  b2rd_cmd_t          cmd,
  output b2rd_status_t       status
);

  logic [RADIX_W-1:0]   radix_eff;
  logic [RADIX_W-1:0]   radix_clamped;
  logic [WORK_W-1:0]    work;
  logic [WORK_W-1:0]    work_next;
  logic [RADIX_W-1:0]   rem;
  logic [RADIX_W-1:0]   rem_next;
  logic [DIV_CNT_W-1:0] step;
  logic [ADDR_W-1:0]    cnt;
  logic [ADDR_W-1:0]    ptr;
  logic                 wr_en;
  logic [DIGIT_W-1:0]   rd_data;

  // saturate to the supported bases
  always_comb begin
    if (radix < RADIX_MIN) begin
      radix_clamped = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_clamped = RADIX_MAX;
    end else begin
      radix_clamped = radix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_eff <= RADIX_RESET;
    end else if (cfg_valid) begin
      radix_eff <= radix_clamped;
    end
  end

  // restoring division, several quotient bits per cycle
  always_comb begin
    logic [WORK_W-1:0]  w;
    logic [RADIX_W-1:0] r;
    logic [RADIX_W:0]   t;
    w = work;
    r = rem;
    t = '0;
    for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
      t = {r, w[WORK_W-1]};
      w = {w[WORK_W-2:0], 1'b0};
      if (t >= {1'b0, radix_eff}) begin
        t    = t - {1'b0, radix_eff};
        w[0] = 1'b1;
      end
      r = t[RADIX_W-1:0];
    end
    work_next = w;
    rem_next  = r;
  end

  assign status.div_last  = (step == DIV_CNT_W'(DIV_CYCLES - 1));
  assign status.conv_done = (work_next == '0) || (cnt == ADDR_W'(MAX_DIGITS - 1));
  assign status.ptr_zero  = (ptr == '0);
  assign status.out_free  = !out_valid || !out_stall;

  assign wr_en = cmd.div && status.div_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work <= {{(WORK_W - VALUE_W){1'b0}}, value};
      rem  <= '0;
      step <= '0;
      cnt  <= '0;
    end else if (cmd.div) begin
      work <= work_next;
      if (status.div_last) begin
        rem  <= '0;
        step <= '0;
        cnt  <= cnt + 1'b1;
        ptr  <= cnt;
      end else begin
        rem  <= rem_next;
        step <= step + 1'b1;
      end
    end else if (cmd.emit_ld) begin
      ptr <= ptr - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      digit <= rd_data;
      last  <= (ptr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  b2rd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digit_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt),
    .wr_data (rem_next),
    .rd_en   (cmd.emit_rd),
    .rd_addr (ptr),
    .rd_data (rd_data)
  );

endmodule

// ----- test/binary_to_radix_digits_test.sv -----
module binary_to_radix_digits_test
  import b2rd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGIT_SLOTS = 31;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 26;
  localparam logic [VALUE_W-1:0] VALUE_TOP = {VALUE_W{1'b1}};

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } digit_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [RADIX_W-1:0] radix = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [DIGIT_W-1:0] digit;
  logic               last;

  logic [VALUE_W-1:0] values_to_send[$];
  digit_beat_t        pending_digits[$];
  logic [RADIX_W-1:0] base_setting = RADIX_RESET;
  logic               in_beat = 1'b0;
  logic               steady = 1'b0;
  int unsigned        issued_items = 0;
  int unsigned        accepted_items = 0;
  int unsigned        mismatches = 0;
  int unsigned        quiet_cycles = 0;
  digit_beat_t        want;

  binary_to_radix_digits #(.MAX_DIGITS(DIGIT_SLOTS)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .radix    (radix),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .digit    (digit),
    .last     (last)
  );

  always #6 clk = ~clk;

  // expected digits of one value, most significant first
  function automatic void predict_digits(input logic [VALUE_W-1:0] v_in,
                                         input logic [RADIX_W-1:0] setting);
    logic [DIGIT_W-1:0] slots[DIGIT_SLOTS];
    int unsigned base;
    int unsigned rest;
    int unsigned n;
    digit_beat_t b;
    if (setting < RADIX_MIN) base = RADIX_MIN;
    else if (setting > RADIX_MAX) base = RADIX_MAX;
    else base = setting;
    rest = v_in;
    n = 0;
    do begin
      slots[n] = DIGIT_W'(rest % base);
      rest = rest / base;
      n++;
    end while (rest != 0 && n < DIGIT_SLOTS);
    for (int k = n - 1; k >= 0; k--) begin
      b.digit = slots[k];
      b.last = (k == 0);
      pending_digits.push_back(b);
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = VALUE_TOP;
      2: v = VALUE_W'($urandom_range(15));
      3: v = VALUE_W'($urandom_range(1000));
      4: v = VALUE_W'((VALUE_W'(1) << $urandom_range(VALUE_W - 1)) - $urandom_range(1));
      default: v = VALUE_W'($urandom());
    endcase
    return v;
  endfunction

  function automatic void queue_value(input logic [VALUE_W-1:0] v);
    values_to_send.push_back(v);
    issued_items++;
  endfunction

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat) begin
      if (values_to_send.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
        value <= values_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 31);
  end

  // input beats feed the predictor
  always @(posedge clk) begin
    in_beat <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      predict_digits(value, base_setting);
      accepted_items <= accepted_items + 1;
    end
  end

  // output beats against the oldest expected digit
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_digits.size() == 0) begin
        note_mismatch($sformatf("unexpected digit %0d last %0b", digit, last));
      end else begin
        want = pending_digits.pop_front();
        if (digit !== want.digit || last !== want.last)
          note_mismatch($sformatf("digit mismatch: expected %0d last %0b, got %0d last %0b",
                                  want.digit, want.last, digit, last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic set_base(input logic [RADIX_W-1:0] r);
    @(negedge clk);
    cfg_valid <= 1'b1;
    radix <= r;
    do @(posedge clk); while (!cfg_ready);
    base_setting = r;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (accepted_items != issued_items || pending_digits.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [RADIX_W-1:0] phase_bases[$];
    phase_bases = '{4'd2, 4'd15, 4'd0, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
                    4'd11, 4'd12, 4'd13, 4'd14, 4'd1, 4'd10};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset base of ten
    queue_value('0);
    queue_value(VALUE_W'(1));
    queue_value(VALUE_W'(9));
    queue_value(VALUE_W'(10));
    queue_value(VALUE_W'(1000000000));
    queue_value(VALUE_W'(1) << (VALUE_W - 1));
    queue_value(VALUE_TOP);
    drain();

    // base below two saturates, longest run of digits
    set_base(4'd1);
    queue_value(VALUE_TOP);
    queue_value('0);
    queue_value(VALUE_W'(1));
    queue_value(31'h2AAAAAAA);
    queue_value(31'h55555555);
    drain();

    // base above ten saturates
    set_base(4'd15);
    queue_value(VALUE_TOP);
    queue_value('0);
    queue_value(VALUE_W'(999));
    drain();

    foreach (phase_bases[p]) begin
      set_base(phase_bases[p]);
      steady = (p == 5);
      repeat (PHASE_ITEMS) queue_value(pick_value());
      drain();
    end
    steady = 1'b0;

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/b2rd_pkg.sv
rtl/b2rd_ram.sv
rtl/b2rd_ctrl.sv
rtl/b2rd_dp.sv
rtl/binary_to_radix_digits.sv
test/binary_to_radix_digits_test.sv
